// ----- rtl/hfii_pkg.sv -----
// ----------------------------------------------------------------------------
// hfii_pkg
// Types and fixed constants shared by the Haar feature extractor modules.
// ----------------------------------------------------------------------------
package hfii_pkg;

  // input item kinds (tuser)
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [8:0] REG_DIM_RESET = 9'd256;

  // edge offset = ((k*size + 30) * RECIP) >> RECIP_SHIFT, exact for k*size+30 < 23831
  localparam logic [14:0] EDGE_BIAS   = 15'd30;
  localparam logic [14:0] RECIP       = 15'd17477;
  localparam int          RECIP_SHIFT = 20;

  // normalization: numerator scale fd*25, denominator fn*(scale+1)^2
  localparam logic [14:0] NUM_TWO   = 15'd50;
  localparam logic [14:0] NUM_THREE = 15'd75;
  localparam logic [10:0] DEN_TWO_S0   = 11'd255;
  localparam logic [10:0] DEN_TWO_S1   = 11'd1020;
  localparam logic [10:0] DEN_THREE_S0 = 11'd510;
  localparam logic [10:0] DEN_THREE_S1 = 11'd2040;

  localparam int DVD_W  = 51;
  localparam int DVS_W  = 27;
  localparam int QUOT_W = 17;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EDGE,
    ST_READ,
    ST_DRAIN,
    ST_MNUM,
    ST_MDEN1,
    ST_MDEN2,
    ST_DIVGO,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/hfii_store.sv -----
// ----------------------------------------------------------------------------
// hfii_store
// Integral image memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hfii_store #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [23:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [23:0]   rd_data
);

  logic [23:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/hfii_div.sv -----
// ----------------------------------------------------------------------------
// hfii_div
// Restoring divider, one dividend bit per cycle; keeps the low quotient bits
// and flags any quotient bit above them as overflow.
// ----------------------------------------------------------------------------
module hfii_div
  import hfii_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;
  logic [QUOT_W-1:0] q_r;
  logic              ovf_r;
  logic [5:0]        cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DVS_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      cnt_r <= 6'(DVD_W);
    end else if (busy_r) begin
      rem_r <= ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      q_r   <= {q_r[QUOT_W-2:0], ge};
      ovf_r <= ovf_r | q_r[QUOT_W-1];
      cnt_r <= cnt_r - 6'd1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.quot = q_r;

endmodule

// ----- rtl/haar_feature_from_integral_image_top.sv -----
// ----------------------------------------------------------------------------
// haar_feature_from_integral_image_top
// Haar feature extraction from a stored integral image, Q1.15 output.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / data                          | tuser
//  in_     | in  | row,col,sum,cx,cy,w,h,feature_index  | opcode
//  out_    | out | feature_value, feature_echo           | in_bounds
//  cfg_    | in  | cfg_index, cfg_data (9 bits)          | -
//
// A write item is stored on its transfer. An extract item passes, after its
// transfer, through index decode, edge offsets on the shared multiplier,
// memory reads of the box corners, normalization products and divider start,
// the serial divider and a finish state, before the input is ready again.
// Out-of-bounds or unknown features go straight to the finish state.
// Reset is synchronous; the store is not cleared. A stalled output holds
// the next result in the finish state until the output register frees up.
module haar_feature_from_integral_image_top
  import hfii_pkg::*;
#(
  parameter int MAX_COLUMNS    = 256,
  parameter int MAX_ROWS       = 256,
  parameter int GRID_POSITIONS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] write_row, [15:8] write_column, [39:16] sum_value, [47:40] center_x,
  // [55:48] center_y, [63:56] patch_width, [71:64] patch_height,
  // [80:72] feature_index, [87:81] zero
  input  logic [87:0] in_tdata,
  input  logic [0:0]  in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] feature_value, [24:16] feature_echo, [31:25] zero
  output logic [31:0] out_tdata,
  output logic [0:0]  out_tuser,  // [0] in_bounds
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int GW    = $clog2(GRID_POSITIONS);
  localparam int GG    = GRID_POSITIONS * GRID_POSITIONS;
  localparam int NFEAT = 8 * GG;
  localparam int GD    = GRID_POSITIONS - 1;

  // grid centres in sixtieths
  logic [5:0] centre_tab [0:GRID_POSITIONS-1];
  for (genvar g = 0; g < GRID_POSITIONS; g++) begin : g_centre
    localparam int CV = 12 + (72 * g + GD) / (2 * GD);
    assign centre_tab[g] = 6'(CV);
  end

  state_t state_r, state_nxt;

  logic [8:0] cols_r, rows_r;
  logic       out_valid_r;
  logic [15:0] out_value_r;
  logic [8:0]  out_echo_r;
  logic        out_inb_r;

  // latched item
  logic [7:0] px_r, py_r, w_r, h_r;
  logic [8:0] fidx_r;
  logic [1:0] kind_r;
  logic       scale_r, zero_r, inside_r;
  logic [6:0] r_r;
  logic [GW-1:0] gy_r, gx_r;
  logic [2:0] e_r;
  logic       ph_r;
  logic [14:0] p_r;
  logic [8:0] sp0_r, sp1_r, sp2_r, sp3_r, sh0_r, sh1_r;
  logic [3:0] rc_r;
  logic       tag_v_r, tag_neg_r, tag_dbl_r;
  logic signed [28:0] acc_r;
  logic       neg_r;
  logic [34:0] num_r;
  logic [18:0] den1_r;
  logic [26:0] den_r;

  // input fields
  logic        opcode;
  logic [7:0]  f_row, f_col, f_cx, f_cy, f_w, f_h;
  logic [23:0] f_sum;
  logic [8:0]  f_fidx;
  assign opcode = in_tuser[0];
  assign f_row  = in_tdata[7:0];
  assign f_col  = in_tdata[15:8];
  assign f_sum  = in_tdata[39:16];
  assign f_cx   = in_tdata[47:40];
  assign f_cy   = in_tdata[55:48];
  assign f_w    = in_tdata[63:56];
  assign f_h    = in_tdata[71:64];
  assign f_fidx = in_tdata[80:72];

  logic in_acc;
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  // patch check
  logic [7:0] half_w, half_h, px, py;
  logic [8:0] pxw, pyh;
  logic       patch_ok, feat_ok;
  logic [6:0] rest;
  logic       rest_scale;
  assign half_w = {1'b0, f_w[7:1]};
  assign half_h = {1'b0, f_h[7:1]};
  assign px     = f_cx - half_w;
  assign py     = f_cy - half_h;
  assign pxw    = {1'b0, px} + {1'b0, f_w};
  assign pyh    = {1'b0, py} + {1'b0, f_h};
  assign patch_ok = (f_w != 8'd0) && (f_h != 8'd0) && (f_cx >= half_w) && (f_cy >= half_h)
                 && (32'(pxw) < 32'(cols_r)) && (32'(pxw) < MAX_COLUMNS)
                 && (32'(pyh) < 32'(rows_r)) && (32'(pyh) < MAX_ROWS);
  assign feat_ok    = 32'(f_fidx) < NFEAT;
  assign rest       = f_fidx[8:2];
  assign rest_scale = 32'(rest) >= GG;

  // edge geometry; kinds with kind[0]=0 split along x
  logic       split_y, three;
  logic [6:0] s_half, s_full, step, split_base, short_base, k_e;
  logic [5:0] cx_tab, cy_tab;
  logic [7:0] size_e, origin_e;
  assign split_y = kind_r[0];
  assign three   = kind_r[1];
  assign s_half  = scale_r ? 7'd12 : 7'd6;
  assign s_full  = scale_r ? 7'd24 : 7'd12;
  assign step    = three ? (scale_r ? 7'd8 : 7'd4) : s_half;
  assign cx_tab  = centre_tab[gx_r];
  assign cy_tab  = centre_tab[gy_r];
  assign split_base = {1'b0, split_y ? cy_tab : cx_tab} - s_half;
  assign short_base = {1'b0, split_y ? cx_tab : cy_tab} - s_half;

  always_comb begin
    if (!e_r[2]) begin
      k_e      = split_base + 7'(7'(e_r[1:0]) * step);
      size_e   = split_y ? h_r : w_r;
      origin_e = split_y ? py_r : px_r;
    end else begin
      k_e      = e_r[0] ? (short_base + s_full) : short_base;
      size_e   = split_y ? w_r : h_r;
      origin_e = split_y ? px_r : py_r;
    end
  end

  // corner addressing: box j = rc[3:2], corner c = rc[1:0]
  logic [8:0] a_lo, a_hi, y_sel, x_sel, y1, y2, x1, x2;
  logic       last_read, rd_neg, rd_dbl;
  always_comb begin
    case (rc_r[3:2])
      2'd0:    begin a_lo = sp0_r; a_hi = sp1_r; end
      2'd1:    begin a_lo = sp1_r; a_hi = sp2_r; end
      default: begin a_lo = sp2_r; a_hi = sp3_r; end
    endcase
    if (split_y) begin
      y1 = a_lo; y2 = a_hi; x1 = sh0_r; x2 = sh1_r;
    end else begin
      x1 = a_lo; x2 = a_hi; y1 = sh0_r; y2 = sh1_r;
    end
    case (rc_r[1:0])
      2'd0:    begin y_sel = y1; x_sel = x1; end
      2'd1:    begin y_sel = y2; x_sel = x2; end
      2'd2:    begin y_sel = y1; x_sel = x2; end
      default: begin y_sel = y2; x_sel = x1; end
    endcase
  end
  assign last_read = rc_r == (three ? 4'd11 : 4'd7);
  assign rd_neg    = rc_r[1] ^ (rc_r[3:2] == 2'd1);
  assign rd_dbl    = three & (rc_r[3:2] == 2'd1);

  // memory
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [23:0]   rd_data;
  assign wr_en   = in_acc && (opcode == OP_WRITE) && (32'(f_row) < MAX_ROWS)
                && (32'(f_col) < MAX_COLUMNS);
  assign wr_addr = {RW'(f_row), CW'(f_col)};
  assign rd_addr = {RW'(y_sel), CW'(x_sel)};

  hfii_store #(.AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (f_sum),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared multiplier
  logic [27:0] mul_a;
  logic [14:0] mul_b;
  logic [42:0] mul_p;
  logic [27:0] mag;
  logic [10:0] fnsc;
  assign mag   = acc_r[28] ? 28'(-acc_r) : 28'(acc_r);
  assign mul_p = 43'(mul_a) * 43'(mul_b);

  always_comb begin
    case ({three, scale_r})
      2'b00:   fnsc = DEN_TWO_S0;
      2'b01:   fnsc = DEN_TWO_S1;
      2'b10:   fnsc = DEN_THREE_S0;
      default: fnsc = DEN_THREE_S1;
    endcase
  end

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  hfii_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  logic load_out;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && opcode == OP_EXTRACT) begin
          state_nxt = (patch_ok && feat_ok) ? ST_DECODE : ST_FINISH;
        end
      end
      ST_DECODE: if (32'(r_r) < GRID_POSITIONS) state_nxt = ST_EDGE;
      ST_EDGE:   if (ph_r && e_r == 3'd5) state_nxt = ST_READ;
      ST_READ:   if (last_read) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_MNUM;
      ST_MNUM:   state_nxt = ST_MDEN1;
      ST_MDEN1:  state_nxt = ST_MDEN2;
      ST_MDEN2:  state_nxt = ST_DIVGO;
      ST_DIVGO:  state_nxt = ST_DIV;
      ST_DIV:    if (div_rsp.done) state_nxt = ST_FINISH;
      ST_FINISH: if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready        = 1'b0;
    load_out         = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, num_r, 15'd0} + DVD_W'(den_r[26:1]);
    div_req.divisor  = den_r;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_EDGE: begin
        if (!ph_r) begin
          mul_a = 28'(size_e);
          mul_b = 15'(k_e);
        end else begin
          mul_a = 28'(p_r);
          mul_b = RECIP;
        end
      end
      ST_MNUM: begin
        mul_a = mag;
        mul_b = three ? NUM_THREE : NUM_TWO;
      end
      ST_MDEN1: begin
        mul_a = 28'(fnsc);
        mul_b = 15'(w_r);
      end
      ST_MDEN2: begin
        mul_a = 28'(den1_r);
        mul_b = 15'(h_r);
      end
      ST_DIVGO:  div_req.start = 1'b1;
      ST_FINISH: load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // saturated result
  logic [15:0] value;
  always_comb begin
    if (zero_r) begin
      value = 16'd0;
    end else if (neg_r) begin
      value = (div_rsp.ovf || div_rsp.quot > 17'd32768) ? 16'h8000
            : 16'(~div_rsp.quot + 17'd1);
    end else begin
      value = (div_rsp.ovf || div_rsp.quot > 17'd32767) ? 16'h7FFF : div_rsp.quot[15:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cols_r      <= REG_DIM_RESET;
      rows_r      <= REG_DIM_RESET;
      tag_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tag_v_r <= state_r == ST_READ;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COLUMNS: cols_r <= cfg_data;
          REG_ROWS:    rows_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (tag_v_r) begin
      acc_r <= tag_neg_r ? acc_r - 29'({5'd0, rd_data} << tag_dbl_r)
                         : acc_r + 29'({5'd0, rd_data} << tag_dbl_r);
    end
    tag_neg_r <= rd_neg;
    tag_dbl_r <= rd_dbl;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          px_r     <= px;
          py_r     <= py;
          w_r      <= f_w;
          h_r      <= f_h;
          fidx_r   <= f_fidx;
          kind_r   <= f_fidx[1:0];
          scale_r  <= rest_scale;
          r_r      <= rest_scale ? rest - 7'(GG) : rest;
          gy_r     <= '0;
          inside_r <= patch_ok;
          zero_r   <= !(patch_ok && feat_ok);
          e_r      <= 3'd0;
          ph_r     <= 1'b0;
          rc_r     <= 4'd0;
          acc_r    <= '0;
        end
      end
      ST_DECODE: begin
        gx_r <= GW'(r_r);
        if (32'(r_r) >= GRID_POSITIONS) begin
          r_r  <= r_r - 7'(GRID_POSITIONS);
          gy_r <= gy_r + GW'(1);
        end
      end
      ST_EDGE: begin
        ph_r <= !ph_r;
        if (!ph_r) begin
          p_r <= mul_p[14:0] + EDGE_BIAS;
        end else begin
          e_r <= e_r + 3'd1;
          case (e_r)
            3'd0:    sp0_r <= {1'b0, origin_e} + mul_p[RECIP_SHIFT+8:RECIP_SHIFT];
            3'd1:    sp1_r <= {1'b0, origin_e} + mul_p[RECIP_SHIFT+8:RECIP_SHIFT];
            3'd2:    sp2_r <= {1'b0, origin_e} + mul_p[RECIP_SHIFT+8:RECIP_SHIFT];
            3'd3:    sp3_r <= {1'b0, origin_e} + mul_p[RECIP_SHIFT+8:RECIP_SHIFT];
            3'd4:    sh0_r <= {1'b0, origin_e} + mul_p[RECIP_SHIFT+8:RECIP_SHIFT];
            default: sh1_r <= {1'b0, origin_e} + mul_p[RECIP_SHIFT+8:RECIP_SHIFT];
          endcase
        end
      end
      ST_READ:  rc_r <= rc_r + 4'd1;
      ST_MNUM: begin
        num_r <= mul_p[34:0];
        neg_r <= acc_r[28];
      end
      ST_MDEN1: den1_r <= mul_p[18:0];
      ST_MDEN2: den_r  <= mul_p[26:0];
      ST_FINISH: begin
        if (load_out) begin
          out_value_r <= value;
          out_echo_r  <= fidx_r;
          out_inb_r   <= inside_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {7'd0, out_echo_r, out_value_r};
  assign out_tuser[0] = out_inb_r;

endmodule
